// File: rtl/hte_pkg.sv
// Shared types, mode codes and escape sequence tables for the text escaper.
`default_nettype none

package hte_pkg;

    localparam logic [1:0] MODE_HTML = 2'd0;
    localparam logic [1:0] MODE_JS   = 2'd1;

    localparam int SEQ_MAX_LEN = 6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       out_end_of_text;
    } out_item_t;

    typedef enum logic [3:0] {
        SEQ_NONE,
        SEQ_HTML_AMP,
        SEQ_HTML_APOS,
        SEQ_HTML_QUOT,
        SEQ_HTML_GT,
        SEQ_HTML_LT,
        SEQ_JS_APOS,
        SEQ_JS_QUOT,
        SEQ_JS_BSLASH,
        SEQ_JS_SLASH,
        SEQ_JS_CR,
        SEQ_JS_LF,
        SEQ_JS_LT,
        SEQ_JS_GT
    } seq_code_t;

    typedef struct packed {
        seq_code_t  code;
        logic [7:0] raw;
        logic       eot;
    } cmd_t;

    // Number of output bytes for a sequence code.
    function automatic logic [2:0] seq_len(input seq_code_t code);
        logic [2:0] len;
        unique case (code)
            SEQ_HTML_AMP:  len = 3'd5;
            SEQ_HTML_APOS: len = 3'd6;
            SEQ_HTML_QUOT: len = 3'd6;
            SEQ_HTML_GT:   len = 3'd4;
            SEQ_HTML_LT:   len = 3'd4;
            SEQ_JS_LT:     len = 3'd4;
            SEQ_JS_GT:     len = 3'd4;
            SEQ_JS_APOS, SEQ_JS_QUOT, SEQ_JS_BSLASH, SEQ_JS_SLASH,
            SEQ_JS_CR, SEQ_JS_LF: len = 3'd2;
            default:       len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte at a position of an escape sequence; element 0 is sent first.
    function automatic logic [7:0] seq_byte(input seq_code_t code,
                                            input logic [2:0] idx,
                                            input logic [7:0] raw);
        logic [SEQ_MAX_LEN-1:0][7:0] s;
        s = '0;
        unique case (code)
            SEQ_HTML_AMP: begin
                s[0] = 8'h26; s[1] = 8'h61; s[2] = 8'h6D; s[3] = 8'h70; s[4] = 8'h3B;
            end
            SEQ_HTML_APOS: begin
                s[0] = 8'h26; s[1] = 8'h61; s[2] = 8'h70; s[3] = 8'h6F; s[4] = 8'h73;
                s[5] = 8'h3B;
            end
            SEQ_HTML_QUOT: begin
                s[0] = 8'h26; s[1] = 8'h71; s[2] = 8'h75; s[3] = 8'h6F; s[4] = 8'h74;
                s[5] = 8'h3B;
            end
            SEQ_HTML_GT: begin
                s[0] = 8'h26; s[1] = 8'h67; s[2] = 8'h74; s[3] = 8'h3B;
            end
            SEQ_HTML_LT: begin
                s[0] = 8'h26; s[1] = 8'h6C; s[2] = 8'h74; s[3] = 8'h3B;
            end
            SEQ_JS_APOS:   begin s[0] = 8'h5C; s[1] = 8'h27; end
            SEQ_JS_QUOT:   begin s[0] = 8'h5C; s[1] = 8'h22; end
            SEQ_JS_BSLASH: begin s[0] = 8'h5C; s[1] = 8'h5C; end
            SEQ_JS_SLASH:  begin s[0] = 8'h5C; s[1] = 8'h2F; end
            SEQ_JS_CR:     begin s[0] = 8'h5C; s[1] = 8'h72; end
            SEQ_JS_LF:     begin s[0] = 8'h5C; s[1] = 8'h6E; end
            SEQ_JS_LT: begin
                s[0] = 8'h5C; s[1] = 8'h78; s[2] = 8'h33; s[3] = 8'h63;
            end
            SEQ_JS_GT: begin
                s[0] = 8'h5C; s[1] = 8'h78; s[2] = 8'h33; s[3] = 8'h65;
            end
            default: s[0] = raw;
        endcase
        if (idx < 3'(SEQ_MAX_LEN)) begin
            return s[idx];
        end else begin
            return 8'h00;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/hte_front.sv
// Front end of the text escaper: accepts a text byte and classifies it.
`default_nettype none

module hte_front
    import hte_pkg::*;
(
    input  wire logic       [1:0] escape_mode,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output cmd_t                  push_cmd
);

    seq_code_t code;

    always_comb begin
        code = SEQ_NONE;
        unique case (escape_mode)
            MODE_HTML: begin
                case (s_data.in_byte)
                    8'h26:   code = SEQ_HTML_AMP;
                    8'h27:   code = SEQ_HTML_APOS;
                    8'h22:   code = SEQ_HTML_QUOT;
                    8'h3E:   code = SEQ_HTML_GT;
                    8'h3C:   code = SEQ_HTML_LT;
                    default: code = SEQ_NONE;
                endcase
            end
            MODE_JS: begin
                case (s_data.in_byte)
                    8'h27:   code = SEQ_JS_APOS;
                    8'h22:   code = SEQ_JS_QUOT;
                    8'h5C:   code = SEQ_JS_BSLASH;
                    8'h2F:   code = SEQ_JS_SLASH;
                    8'h0D:   code = SEQ_JS_CR;
                    8'h0A:   code = SEQ_JS_LF;
                    8'h3C:   code = SEQ_JS_LT;
                    8'h3E:   code = SEQ_JS_GT;
                    default: code = SEQ_NONE;
                endcase
            end
            default: code = SEQ_NONE;
        endcase
    end

    assign push_cmd.code = code;
    assign push_cmd.raw  = s_data.in_byte;
    assign push_cmd.eot  = s_data.in_end_of_text;
    assign push_valid    = s_valid;
    assign s_ready       = push_ready;

endmodule

`default_nettype wire

// File: rtl/hte_queue.sv
// Short command queue between the escaper's front and back ends.
`default_nettype none

module hte_queue
    import hte_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hte_back.sv
// Back end of the text escaper: emits the bytes of each queued sequence.
`default_nettype none

module hte_back
    import hte_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      pop_valid,
    output logic           pop_ready,
    input  wire cmd_t      pop_cmd,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;
    logic [2:0] idx_reg, idx_next;
    logic       load_en, is_last;

    assign load_en = !m_valid_reg || m_ready;
    assign is_last = (idx_reg == seq_len(pop_cmd.code) - 3'd1);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        idx_next     = idx_reg;
        pop_ready    = 1'b0;
        if (load_en) begin
            m_valid_next = pop_valid;
            if (pop_valid) begin
                m_data_next.out_byte        = seq_byte(pop_cmd.code, idx_reg, pop_cmd.raw);
                m_data_next.last_of_run     = is_last;
                m_data_next.out_end_of_text = is_last && pop_cmd.eot;
                if (is_last) begin
                    pop_ready = 1'b1;
                    idx_next  = '0;
                end else begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/html_js_text_escaper.sv
// Top level of the HTML and JavaScript text escaper.
// A request is queued, then its first byte goes into the back end's output register.
// Throughput: one output byte per cycle unless m_ready stalls the output; a byte that
// escapes to n bytes gives n output bytes, which the back end emits one byte per cycle.
// Reset: aresetn is synchronous and active low; it empties the queue, drops any
// pending output and returns escape_mode to HTML mode.
`default_nettype none

module html_js_text_escaper
    import hte_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       escape_mode_wr_en,
    input  wire logic [1:0] escape_mode_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    // The user must write the mode register only while the block is idle (the block
    // itself does not enforce this), so the front end can classify each request against its current value.
    logic [1:0] escape_mode_reg, escape_mode_next;

    always_comb begin
        escape_mode_next = escape_mode_reg;
        if (escape_mode_wr_en) begin
            escape_mode_next = escape_mode_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            escape_mode_reg <= MODE_HTML;
        end else begin
            escape_mode_reg <= escape_mode_next;
        end
    end

    logic push_valid, push_ready, pop_valid, pop_ready;
    cmd_t push_cmd, pop_cmd;

    // The front end turns each text byte into a sequence code and the raw byte.
    hte_front u_front (
        .escape_mode (escape_mode_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    // The queue lets new requests arrive while a long sequence is still
    // being sent, and lets the output side stall without losing anything.
    hte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // The back end walks the sequence one byte per cycle, unless m_ready stalls it,
    // into its output register and retires the queue entry with the final byte of the run.
    hte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
